/* hdl/msst_pkg.sv */
// ----------------------------------------------------------------------------
// msst_pkg
// shared types and codes of the multi-slot timer table
// ----------------------------------------------------------------------------
package msst_pkg;

    localparam int SLOT_ID_W = 4;
    localparam int TIME_IN_W = 32;
    localparam int MAX_SLOTS = 16;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_STOP     = 2'd1,
        CMD_STOP_ALL = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        EV_STARTED = 2'd0,
        EV_REFUSED = 2'd1,
        EV_EXPIRED = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

/* hdl/msst_slot_ram.sv */
// ----------------------------------------------------------------------------
// msst_slot_ram
// one-write one-read slot memory, registered read data
// ----------------------------------------------------------------------------
module msst_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/multi_slot_software_timer_table.sv */
// ----------------------------------------------------------------------------
// multi_slot_software_timer_table
// timer slot table: start, stop, stop-all and tick commands, expiry events
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall  | command, interval_ticks, single_shot,
//          |           |                    | timer_id, delta_ticks
//  output  | out       | out_valid/out_stall| event_kind, slot_id, last_event
//
//  start, stop and stop-all do not hold the input; start leaves one beat in the output register
//  a tick holds the input after its beat while it walks: one ram read per slot,
//  then a test of the last slot, a check for the walk end and a send of the last expiry
//  active and one-shot bits live in flip-flops and reset clears them at once; the ram
//  holds interval and remaining time, has no reset and its data is used only behind an active bit
//  a stalled output holds the walk only when a second expiry needs the output register
// ----------------------------------------------------------------------------
module multi_slot_software_timer_table
    import msst_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [TIME_IN_W-1:0] interval_ticks,
    input  logic                 single_shot,
    input  logic [SLOT_ID_W-1:0] timer_id,
    input  logic [TIME_IN_W-1:0] delta_ticks,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           event_kind,
    output logic [SLOT_ID_W-1:0] slot_id,
    output logic                 last_event
);

    localparam int SLOTS = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int TW    = (TIME_BITS < TIME_IN_W) ? TIME_BITS : TIME_IN_W;

    state_t               state_reg, state_next;
    logic [SLOTS-1:0]     active_reg, active_next;
    logic [SLOTS-1:0]     one_shot_reg, one_shot_next;
    logic [CW-1:0]        rd_idx_reg;
    logic                 eval_vld_reg;
    logic [AW-1:0]        eval_idx_reg;
    logic                 pend_vld_reg;
    logic [AW-1:0]        pend_idx_reg;
    logic [TW-1:0]        delta_reg;
    logic                 out_valid_reg;
    logic [1:0]           event_kind_reg, event_kind_next;
    logic [SLOT_ID_W-1:0] slot_id_reg, slot_id_next;
    logic                 last_event_reg, last_event_next;

    logic                 in_accept;
    logic                 out_busy;
    logic                 tick_start;
    logic                 free_found;
    logic [AW-1:0]        free_idx;
    logic [TW-1:0]        in_interval;
    logic [TW-1:0]        eval_ival;
    logic [TW-1:0]        eval_rem;
    logic                 eval_live;
    logic                 eval_hit;
    logic                 walk_step;
    logic                 rd_en;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [2*TW-1:0]      ram_wdata;
    logic [2*TW-1:0]      ram_rdata;
    logic                 out_load;
    logic                 pend_set;
    logic                 pend_clr;
    logic                 walk_done;

    msst_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (AW),
        .DW    (2 * TW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign out_busy    = out_valid_reg && out_stall;
    assign in_stall    = (state_reg != ST_IDLE) || out_busy;
    assign in_accept   = in_valid && !in_stall;
    assign tick_start  = in_accept && (cmd_t'(command) == CMD_TICK);
    assign in_interval = interval_ticks[TW-1:0];
    assign eval_ival   = ram_rdata[2*TW-1:TW];
    assign eval_rem    = ram_rdata[TW-1:0];
    assign walk_done   = (rd_idx_reg == CW'(SLOTS)) && !eval_vld_reg;

    // lowest inactive slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!pend_vld_reg || !out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        active_next     = active_reg;
        one_shot_next   = one_shot_reg;
        ram_we          = 1'b0;
        ram_waddr       = eval_idx_reg;
        ram_wdata       = {eval_ival, eval_rem - delta_reg};
        rd_en           = 1'b0;
        walk_step       = 1'b0;
        out_load        = 1'b0;
        event_kind_next = EV_EXPIRED;
        slot_id_next    = SLOT_ID_W'(pend_idx_reg);
        last_event_next = 1'b0;
        pend_set        = 1'b0;
        pend_clr        = 1'b0;
        eval_live       = eval_vld_reg && active_reg[eval_idx_reg];
        eval_hit        = eval_live && !(eval_rem > delta_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (cmd_t'(command))
                        CMD_START:
                        begin
                            out_load        = 1'b1;
                            last_event_next = 1'b1;
                            if (free_found)
                            begin
                                ram_we                  = 1'b1;
                                ram_waddr               = free_idx;
                                ram_wdata               = {in_interval, in_interval};
                                active_next[free_idx]   = 1'b1;
                                one_shot_next[free_idx] = single_shot;
                                event_kind_next         = EV_STARTED;
                                slot_id_next            = SLOT_ID_W'(free_idx);
                            end
                            else
                            begin
                                event_kind_next = EV_REFUSED;
                                slot_id_next    = '0;
                            end
                        end
                        CMD_STOP:
                        begin
                            if (32'(timer_id) < SLOTS)
                            begin
                                active_next[timer_id[AW-1:0]] = 1'b0;
                            end
                        end
                        CMD_STOP_ALL:
                        begin
                            active_next = '0;
                        end
                        CMD_TICK:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // an expiry with one already pending must push it out first
                walk_step = !(eval_hit && pend_vld_reg && out_busy);
                rd_en     = walk_step && (rd_idx_reg < CW'(SLOTS));
                if (walk_step && eval_live)
                begin
                    if (eval_hit)
                    begin
                        pend_set = 1'b1;
                        out_load = pend_vld_reg;
                        if (one_shot_reg[eval_idx_reg])
                        begin
                            active_next[eval_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {eval_ival, eval_ival};
                        end
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (pend_vld_reg && !out_busy)
                begin
                    out_load        = 1'b1;
                    last_event_next = 1'b1;
                    pend_clr        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            one_shot_reg  <= '0;
            rd_idx_reg    <= '0;
            eval_vld_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            one_shot_reg <= one_shot_next;
            if (tick_start)
            begin
                rd_idx_reg   <= '0;
                eval_vld_reg <= 1'b0;
                pend_vld_reg <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (walk_step)
                begin
                    eval_vld_reg <= rd_en;
                end
                if (pend_set)
                begin
                    pend_vld_reg <= 1'b1;
                end
                else if (pend_clr)
                begin
                    pend_vld_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_start)
        begin
            delta_reg <= delta_ticks[TW-1:0];
        end
        if (rd_en)
        begin
            eval_idx_reg <= rd_idx_reg[AW-1:0];
        end
        if (pend_set)
        begin
            pend_idx_reg <= eval_idx_reg;
        end
        if (out_load)
        begin
            event_kind_reg <= event_kind_next;
            slot_id_reg    <= slot_id_next;
            last_event_reg <= last_event_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = event_kind_reg;
    assign slot_id    = slot_id_reg;
    assign last_event = last_event_reg;

endmodule
